// ===== hw/rtl/etc_pkg.sv =====
// Shared types, codes and helpers for the energy transfer commit block.
`default_nettype none

package etc_pkg;

   // Object table size and derived widths
   localparam int OBJ_COUNT = 256;
   localparam int ADDR_W    = (OBJ_COUNT > 1) ? $clog2(OBJ_COUNT) : 1;
   localparam int IDX_W     = 8;
   localparam int LVL_W     = 32;

   // Step tags in the busy memory; a stored zero marks an entry never busy
   localparam int                 EPOCH_W     = 6;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   // Clearing pass covers two entries per cycle
   localparam int CLR_W = ADDR_W - 1;

   // Item kinds
   typedef enum logic [1:0] {
      KIND_SET      = 2'd0,
      KIND_TRANSFER = 2'd1,
      KIND_STEP     = 2'd2,
      KIND_READ     = 2'd3
   } kind_type;

   // Transfer reject codes
   localparam logic [2:0] REASON_NONE     = 3'd0;
   localparam logic [2:0] REASON_SRC_BUSY = 3'd1;
   localparam logic [2:0] REASON_DST_BUSY = 3'd2;
   localparam logic [2:0] REASON_SRC_LOW  = 3'd3;
   localparam logic [2:0] REASON_DST_FULL = 3'd4;

   typedef struct packed {
      kind_type           kind;
      logic [IDX_W-1:0]   object_index;
      logic [IDX_W-1:0]   partner_index;
      logic [LVL_W-1:0]   amount;
      logic [LVL_W-1:0]   level_value;
      logic [LVL_W-1:0]   capacity_value;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [2:0]         reject_reason;
      logic [LVL_W-1:0]   level_read;
      logic [LVL_W-1:0]   capacity_read;
   } rsp_type;

   // Flag table updates, issued by the evaluate stage
   typedef struct packed {
      logic               mark_busy;
      logic               clear_busy;
      logic               mark_valid;
   } flag_update_type;

   // Flag table lookups for source and destination
   typedef struct packed {
      logic               src_busy;
      logic               dst_busy;
      logic               src_valid;
      logic               dst_valid;
   } flag_status_type;

   // Memory write controls from the evaluate stage
   typedef struct packed {
      logic               lvl_a_we;
      logic [LVL_W-1:0]   lvl_a_data;
      logic               lvl_b_we;
      logic [LVL_W-1:0]   lvl_b_data;
      logic               cap_a_we;
      logic [LVL_W-1:0]   cap_a_data;
   } mem_write_type;

   function automatic logic in_table(input logic [IDX_W-1:0] idx);
      return 32'(idx) < 32'(OBJ_COUNT);
   endfunction

   function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
      return ADDR_W'(idx);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/etc_ram.sv =====
// Generic two-port synchronous RAM, registered read data, read-first.
`default_nettype none

module etc_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             a_we,
   input  wire logic [$clog2(DEPTH)-1:0]         a_addr,
   input  wire logic [WIDTH-1:0]                 a_wdata,
   output      logic [WIDTH-1:0]                 a_rdata,
   input  wire logic                             b_we,
   input  wire logic [$clog2(DEPTH)-1:0]         b_addr,
   input  wire logic [WIDTH-1:0]                 b_wdata,
   output      logic [WIDTH-1:0]                 b_rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Writes; port B wins on a shared address
   always_ff @(posedge clock) begin
      if (a_we) begin
         mem[a_addr] <= a_wdata;
      end
      if (b_we) begin
         mem[b_addr] <= b_wdata;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      a_rdata <= mem[a_addr];
      b_rdata <= mem[b_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/etc_flags.sv =====
// Busy-this-step step tags in a memory, and written marks for every object.
`default_nettype none

module etc_flags (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire etc_pkg::flag_update_type      update,
   input  wire logic [etc_pkg::ADDR_W-1:0]    src_addr,
   input  wire logic [etc_pkg::ADDR_W-1:0]    dst_addr,
   output      etc_pkg::flag_status_type      status,
   output      logic                          clearing
);

   logic [etc_pkg::OBJ_COUNT-1:0] valid_ff;
   logic [etc_pkg::OBJ_COUNT-1:0] valid_in;
   logic [etc_pkg::EPOCH_W-1:0]   epoch_ff;
   logic [etc_pkg::EPOCH_W-1:0]   epoch_in;
   logic                          clear_ff;
   logic                          clear_in;
   logic [etc_pkg::CLR_W-1:0]     clr_cnt_ff;
   logic [etc_pkg::CLR_W-1:0]     clr_cnt_in;
   logic [etc_pkg::ADDR_W-1:0]    tag_a_addr;
   logic [etc_pkg::ADDR_W-1:0]    tag_b_addr;
   logic                          tag_we;
   logic [etc_pkg::EPOCH_W-1:0]   tag_wdata;
   logic [etc_pkg::EPOCH_W-1:0]   tag_a_rd;
   logic [etc_pkg::EPOCH_W-1:0]   tag_b_rd;

   // Next written marks
   always_comb begin
      valid_in = valid_ff;
      if (update.mark_valid) begin
         valid_in[src_addr] = 1'b1;
      end
   end

   // Step tag advance; on wrap, a pass clears every stored tag
   always_comb begin
      epoch_in   = epoch_ff;
      clear_in   = clear_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clear_ff) begin
         clr_cnt_in = clr_cnt_ff + etc_pkg::CLR_W'(1);
         if (clr_cnt_ff == '1) begin
            clear_in = 1'b0;
         end
      end else if (update.clear_busy) begin
         if (epoch_ff == etc_pkg::EPOCH_LAST) begin
            epoch_in   = etc_pkg::EPOCH_FIRST;
            clear_in   = 1'b1;
            clr_cnt_in = '0;
         end else begin
            epoch_in = epoch_ff + etc_pkg::EPOCH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         epoch_ff   <= etc_pkg::EPOCH_FIRST;
         clear_ff   <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         epoch_ff   <= epoch_in;
         clear_ff   <= clear_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Tag memory: item addresses, or an even/odd pair during clearing
   assign tag_a_addr = clear_ff ? {clr_cnt_ff, 1'b0} : src_addr;
   assign tag_b_addr = clear_ff ? {clr_cnt_ff, 1'b1} : dst_addr;
   assign tag_we     = clear_ff || update.mark_busy;
   assign tag_wdata  = clear_ff ? '0 : epoch_ff;

   etc_ram #(
      .DEPTH (etc_pkg::OBJ_COUNT),
      .WIDTH (etc_pkg::EPOCH_W)
   ) u_tag_ram (
      .clock   (clock),
      .a_we    (tag_we),
      .a_addr  (tag_a_addr),
      .a_wdata (tag_wdata),
      .a_rdata (tag_a_rd),
      .b_we    (tag_we),
      .b_addr  (tag_b_addr),
      .b_wdata (tag_wdata),
      .b_rdata (tag_b_rd)
   );

   // Lookups for the item in the update cycle
   assign status.src_busy  = (tag_a_rd == epoch_ff);
   assign status.dst_busy  = (tag_b_rd == epoch_ff);
   assign status.src_valid = valid_ff[src_addr];
   assign status.dst_valid = valid_ff[dst_addr];

   assign clearing = clear_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/etc_eval.sv =====
// Update stage: transfer checks, new levels, write-back controls and result.
`default_nettype none

module etc_eval (
   input  wire logic                           active,
   input  wire etc_pkg::req_type               item,
   input  wire logic [etc_pkg::LVL_W-1:0]      src_lvl_raw,
   input  wire logic [etc_pkg::LVL_W-1:0]      dst_lvl_raw,
   input  wire logic [etc_pkg::LVL_W-1:0]      src_cap_raw,
   input  wire logic [etc_pkg::LVL_W-1:0]      dst_cap_raw,
   input  wire etc_pkg::flag_status_type       flags,
   output      etc_pkg::mem_write_type         wr,
   output      etc_pkg::flag_update_type       upd,
   output      etc_pkg::rsp_type               rsp
);

   logic                        src_in;
   logic                        dst_in;
   logic                        same_obj;
   logic [etc_pkg::LVL_W-1:0]   src_lvl;
   logic [etc_pkg::LVL_W-1:0]   dst_lvl;
   logic [etc_pkg::LVL_W-1:0]   src_cap;
   logic [etc_pkg::LVL_W-1:0]   dst_cap;
   logic [etc_pkg::LVL_W-1:0]   room;
   logic [etc_pkg::LVL_W-1:0]   src_new;
   logic [etc_pkg::LVL_W-1:0]   dst_new;
   logic [2:0]                  reason;
   logic                        is_set;
   logic                        is_xfer;
   logic                        xfer_ok;
   logic                        moves;

   assign src_in   = etc_pkg::in_table(item.object_index);
   assign dst_in   = etc_pkg::in_table(item.partner_index);
   assign same_obj = (item.object_index == item.partner_index);

   // Entries never written read as zero
   assign src_lvl = flags.src_valid ? src_lvl_raw : '0;
   assign dst_lvl = flags.dst_valid ? dst_lvl_raw : '0;
   assign src_cap = flags.src_valid ? src_cap_raw : '0;
   assign dst_cap = flags.dst_valid ? dst_cap_raw : '0;

   assign room    = dst_cap - dst_lvl;
   assign src_new = src_lvl - item.amount;
   assign dst_new = dst_lvl + item.amount;

   // Checks in priority order
   always_comb begin
      if (!src_in || flags.src_busy) begin
         reason = etc_pkg::REASON_SRC_BUSY;
      end else if (!dst_in || flags.dst_busy) begin
         reason = etc_pkg::REASON_DST_BUSY;
      end else if (item.amount > src_lvl) begin
         reason = etc_pkg::REASON_SRC_LOW;
      end else if (dst_lvl > dst_cap) begin
         reason = etc_pkg::REASON_DST_FULL;
      end else if (item.amount > room) begin
         reason = etc_pkg::REASON_DST_FULL;
      end else begin
         reason = etc_pkg::REASON_NONE;
      end
   end

   assign is_set  = active && (item.kind == etc_pkg::KIND_SET);
   assign is_xfer = active && (item.kind == etc_pkg::KIND_TRANSFER);
   assign xfer_ok = is_xfer && (reason == etc_pkg::REASON_NONE);
   assign moves   = xfer_ok && !same_obj;

   // Write-back: port A on the source/object, port B on the destination
   always_comb begin
      wr.lvl_a_we   = moves || (is_set && src_in);
      wr.lvl_a_data = is_set ? item.level_value : src_new;
      wr.lvl_b_we   = moves;
      wr.lvl_b_data = dst_new;
      wr.cap_a_we   = is_set && src_in;
      wr.cap_a_data = item.capacity_value;
   end

   always_comb begin
      upd.mark_busy  = xfer_ok;
      upd.clear_busy = active && (item.kind == etc_pkg::KIND_STEP);
      upd.mark_valid = is_set && src_in;
   end

   // Result reflects the object after this item
   always_comb begin
      rsp.accepted      = xfer_ok;
      rsp.reject_reason = is_xfer ? reason : etc_pkg::REASON_NONE;
      if (!src_in) begin
         rsp.level_read    = '0;
         rsp.capacity_read = '0;
      end else if (is_set) begin
         rsp.level_read    = item.level_value;
         rsp.capacity_read = item.capacity_value;
      end else begin
         rsp.level_read    = moves ? src_new : src_lvl;
         rsp.capacity_read = src_cap;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/energy_transfer_commit.sv =====
// Top level of the energy transfer commit block.
//
// Each accepted item has an accept cycle and a write-back cycle: in the
// accept cycle the level, capacity and busy-tag memories are addressed
// with the source and destination, and in the following cycle the
// registered read data is checked, the new levels and busy tags are
// written back and busy is held. The result strobes on rsp_valid in the
// cycle after that, for exactly one cycle, and cannot be held off; a new
// item may be started in that same cycle unless a tag clearing pass has
// begun. Throughput is set by the registered read of the object memories
// followed by the write-back cycle. Busy flags are kept as step tags in a
// memory: busy stays high after reset while the tag memory is cleared two
// entries a cycle, and the same pass follows every 63rd new step, when the
// step tag wraps. Written marks are flip-flops cleared at reset.
`default_nettype none

module energy_transfer_commit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire etc_pkg::req_type   req_item,
   output      logic               rsp_valid,
   output      etc_pkg::rsp_type   rsp_item
);

   logic                          active_ff;
   logic                          active_in;
   etc_pkg::req_type              item_ff;
   etc_pkg::req_type              item_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   etc_pkg::rsp_type              rsp_item_ff;
   etc_pkg::rsp_type              rsp_item_in;

   logic                          take;
   logic                          clearing;
   logic [etc_pkg::ADDR_W-1:0]    addr_a;
   logic [etc_pkg::ADDR_W-1:0]    addr_b;
   logic [etc_pkg::ADDR_W-1:0]    item_src;
   logic [etc_pkg::ADDR_W-1:0]    item_dst;
   logic [etc_pkg::LVL_W-1:0]     lvl_a_rd;
   logic [etc_pkg::LVL_W-1:0]     lvl_b_rd;
   logic [etc_pkg::LVL_W-1:0]     cap_a_rd;
   logic [etc_pkg::LVL_W-1:0]     cap_b_rd;
   etc_pkg::mem_write_type        wr;
   etc_pkg::flag_update_type      upd;
   etc_pkg::flag_status_type      flags;

   assign busy = active_ff || clearing || reset;
   assign take = start && !busy;

   assign item_src = etc_pkg::to_addr(item_ff.object_index);
   assign item_dst = etc_pkg::to_addr(item_ff.partner_index);

   // Memory addressing: new item when idle, held item during write-back
   assign addr_a = active_ff ? item_src : etc_pkg::to_addr(req_item.object_index);
   assign addr_b = active_ff ? item_dst : etc_pkg::to_addr(req_item.partner_index);

   etc_ram #(
      .DEPTH (etc_pkg::OBJ_COUNT),
      .WIDTH (etc_pkg::LVL_W)
   ) u_level_ram (
      .clock   (clock),
      .a_we    (wr.lvl_a_we),
      .a_addr  (addr_a),
      .a_wdata (wr.lvl_a_data),
      .a_rdata (lvl_a_rd),
      .b_we    (wr.lvl_b_we),
      .b_addr  (addr_b),
      .b_wdata (wr.lvl_b_data),
      .b_rdata (lvl_b_rd)
   );

   etc_ram #(
      .DEPTH (etc_pkg::OBJ_COUNT),
      .WIDTH (etc_pkg::LVL_W)
   ) u_capacity_ram (
      .clock   (clock),
      .a_we    (wr.cap_a_we),
      .a_addr  (addr_a),
      .a_wdata (wr.cap_a_data),
      .a_rdata (cap_a_rd),
      .b_we    (1'b0),
      .b_addr  (addr_b),
      .b_wdata ('0),
      .b_rdata (cap_b_rd)
   );

   etc_flags u_flags (
      .clock    (clock),
      .reset    (reset),
      .update   (upd),
      .src_addr (addr_a),
      .dst_addr (addr_b),
      .status   (flags),
      .clearing (clearing)
   );

   etc_eval u_eval (
      .active      (active_ff),
      .item        (item_ff),
      .src_lvl_raw (lvl_a_rd),
      .dst_lvl_raw (lvl_b_rd),
      .src_cap_raw (cap_a_rd),
      .dst_cap_raw (cap_b_rd),
      .flags       (flags),
      .wr          (wr),
      .upd         (upd),
      .rsp         (rsp_item_in)
   );

   // Sequencing: accept cycle, then write-back cycle
   assign active_in    = take;
   assign item_in      = take ? req_item : item_ff;
   assign rsp_valid_in = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A result strobe only follows a write-back cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(active_ff))
      else $error("result strobe without a write-back cycle");

   // Write-back lasts exactly one cycle
   a_work_one_cycle: assert property (@(posedge clock) disable iff (reset)
      active_ff |=> !active_ff && rsp_valid_ff)
      else $error("write-back cycle not followed by a result");

   // An accepted transfer never carries a reject code
   a_accept_no_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.accepted |->
         rsp_item_ff.reject_reason == etc_pkg::REASON_NONE)
      else $error("accepted transfer with reject code");

   // No memory write outside the write-back cycle
   a_write_in_work: assert property (@(posedge clock) disable iff (reset)
      (wr.lvl_a_we || wr.lvl_b_we || wr.cap_a_we) |-> active_ff)
      else $error("memory write while idle");

   // The tag clearing pass never overlaps an item in write-back
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !active_ff)
      else $error("tag clearing during write-back");

endmodule

`default_nettype wire

// ===== test/energy_transfer_commit_tb.sv =====
// Testbench for energy_transfer_commit: directed rows, then random items checked by a predictor.
`timescale 1ns / 100ps

module energy_transfer_commit_tb;
   import etc_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int RAND_ITEMS  = 1600;
   localparam int DRAIN_WAIT  = 10;
   localparam int ROW_COUNT   = 25;

   // One directed row: the item, and its outcome where it is typed in
   typedef struct packed {
      kind_type     kind;
      logic [7:0]   obj;
      logic [7:0]   par;
      logic [31:0]  amt;
      logic [31:0]  lv;
      logic [31:0]  cv;
      bit           has_exp;
      logic         acc;
      logic [2:0]   why;
      logic [31:0]  lr;
      logic [31:0]  cr;
   } stim_row_type;

   localparam stim_row_type STIM_ROWS [ROW_COUNT] = '{
      // reads after reset
      '{KIND_READ, 8'd0, 8'd255, '1, '1, '1, 1'b1, 1'b0, REASON_NONE, 32'd0, 32'd0},
      '{KIND_READ, 8'd255, 8'd0, '1, '1, '1, 1'b1, 1'b0, REASON_NONE, 32'd0, 32'd0},
      // zero amount between empty objects
      '{KIND_TRANSFER, 8'd0, 8'd1, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      '{KIND_SET, 8'd0, 8'd0, 32'd0, '1, '1, 1'b1, 1'b0, REASON_NONE, '1, '1},
      '{KIND_SET, 8'd255, 8'd0, '1, 32'd0, '1, 1'b1, 1'b0, REASON_NONE, 32'd0, '1},
      '{KIND_TRANSFER, 8'd0, 8'd255, '1, 32'd0, 32'd0, 1'b1, 1'b0, REASON_SRC_BUSY, '1, '1},
      '{KIND_TRANSFER, 8'd2, 8'd1, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, REASON_DST_BUSY, 32'd0,
        32'd0},
      '{KIND_STEP, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, REASON_NONE, '1, '1},
      // full-scale move, then the source is busy
      '{KIND_TRANSFER, 8'd0, 8'd255, '1, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      '{KIND_TRANSFER, 8'd255, 8'd0, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      '{KIND_STEP, 8'd255, 8'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      // source short
      '{KIND_TRANSFER, 8'd0, 8'd255, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      // level above capacity: no room even for zero units
      '{KIND_SET, 8'd3, 8'd0, 32'd0, 32'd10, 32'd5, 1'b1, 1'b0, REASON_NONE, 32'd10, 32'd5},
      '{KIND_TRANSFER, 8'd255, 8'd3, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      // self transfer
      '{KIND_SET, 8'd5, 8'd0, 32'd0, 32'd50, 32'd100, 1'b1, 1'b0, REASON_NONE, 32'd50, 32'd100},
      '{KIND_TRANSFER, 8'd5, 8'd5, 32'd50, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      '{KIND_TRANSFER, 8'd5, 8'd6, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      '{KIND_STEP, 8'd5, 8'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      // room boundary: one over, then exactly full
      '{KIND_TRANSFER, 8'd255, 8'd5, 32'd51, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0,
        32'd0},
      '{KIND_TRANSFER, 8'd255, 8'd5, 32'd50, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0,
        32'd0},
      '{KIND_READ, 8'd5, 8'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0},
      // alternating bit patterns
      '{KIND_SET, 8'hAA, 8'h55, 32'h5555_5555, 32'hAAAA_AAAA, '1, 1'b1, 1'b0, REASON_NONE,
        32'hAAAA_AAAA, '1},
      '{KIND_SET, 8'h55, 8'hAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 1'b1, 1'b0,
        REASON_NONE, 32'h5555_5555, 32'h5555_5555},
      '{KIND_TRANSFER, 8'h55, 8'hAA, 32'h5555_5555, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE,
        32'd0, 32'd0},
      '{KIND_READ, 8'hAA, 8'h55, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, REASON_NONE, 32'd0, 32'd0}
   };

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   req_type   req_item;
   logic      rsp_valid;
   rsp_type   rsp_item;

   // Predictor copy of the object table
   logic [LVL_W-1:0] level_tab [OBJ_COUNT];
   logic [LVL_W-1:0] cap_tab   [OBJ_COUNT];
   bit               busy_tab  [OBJ_COUNT];

   rsp_type outcome_q [$];
   int unsigned mismatch_cnt;
   int unsigned idle_cycles;

   energy_transfer_commit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one item to the predictor table and return its outcome
   function automatic rsp_type apply_item(input req_type r);
      rsp_type     o;
      logic [2:0]  why;
      int unsigned src;
      int unsigned dst;
      bit          src_in;
      bit          dst_in;
      src    = r.object_index;
      dst    = r.partner_index;
      src_in = src < OBJ_COUNT;
      dst_in = dst < OBJ_COUNT;
      o      = '0;
      why    = REASON_NONE;
      case (r.kind)
         KIND_SET: begin
            if (src_in) begin
               level_tab[src] = r.level_value;
               cap_tab[src]   = r.capacity_value;
            end
         end
         KIND_TRANSFER: begin
            if (!src_in || busy_tab[src]) begin
               why = REASON_SRC_BUSY;
            end else if (!dst_in || busy_tab[dst]) begin
               why = REASON_DST_BUSY;
            end else if (r.amount > level_tab[src]) begin
               why = REASON_SRC_LOW;
            end else if (level_tab[dst] > cap_tab[dst] ||
                         r.amount > cap_tab[dst] - level_tab[dst]) begin
               why = REASON_DST_FULL;
            end else begin
               // self transfer leaves the level alone
               if (src != dst) begin
                  level_tab[dst] = level_tab[dst] + r.amount;
                  level_tab[src] = level_tab[src] - r.amount;
               end
               busy_tab[src] = 1'b1;
               busy_tab[dst] = 1'b1;
            end
            o.accepted      = (why == REASON_NONE);
            o.reject_reason = why;
         end
         KIND_STEP: begin
            foreach (busy_tab[k]) busy_tab[k] = 1'b0;
         end
         default: ;
      endcase
      o.level_read    = src_in ? level_tab[src] : '0;
      o.capacity_read = src_in ? cap_tab[src] : '0;
      return o;
   endfunction

   // Mostly a small pool of objects so transfers collide
   function automatic logic [IDX_W-1:0] pick_index();
      if ($urandom_range(99, 0) < 80) return IDX_W'($urandom_range(7, 0));
      return IDX_W'($urandom_range(255, 0));
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned sel;
      sel = $urandom_range(99, 0);
      if (sel < 55) return 0;
      if (sel < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   function automatic req_type random_item();
      req_type     r;
      int unsigned sel;
      int unsigned src;
      r.object_index   = pick_index();
      r.partner_index  = pick_index();
      r.amount         = $urandom;
      r.level_value    = $urandom;
      r.capacity_value = $urandom;
      src = r.object_index;
      sel = $urandom_range(99, 0);
      if (sel < 15) begin
         r.kind = KIND_SET;
         sel = $urandom_range(99, 0);
         if (sel < 10) begin
            r.level_value    = $urandom_range(1, 0) ? '1 : '0;
            r.capacity_value = $urandom_range(1, 0) ? '1 : '0;
         end else if (sel < 20) begin
            // level above capacity
            r.capacity_value = $urandom_range(1000, 0);
            r.level_value    = r.capacity_value + $urandom_range(100, 1);
         end else if (sel >= 50) begin
            r.capacity_value = $urandom_range(100000, 0);
            r.level_value    = $urandom_range(r.capacity_value, 0);
         end
      end else if (sel < 75) begin
         r.kind = KIND_TRANSFER;
         if ($urandom_range(99, 0) < 10) r.partner_index = r.object_index;
         sel = $urandom_range(99, 0);
         if (sel < 50 && src < OBJ_COUNT) r.amount = $urandom_range(level_tab[src], 0);
         else if (sel < 65) r.amount = '0;
         else if (sel < 80) r.amount = $urandom_range(1000, 1);
      end else if (sel < 85) begin
         r.kind = KIND_STEP;
      end else begin
         r.kind = KIND_READ;
      end
      return r;
   endfunction

   // Present one item after a gap and hold it until taken
   task automatic send_item(input req_type r, input int unsigned gap,
                            input bit use_typed, input rsp_type typed);
      rsp_type pred;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      pred = apply_item(r);
      outcome_q.push_back(use_typed ? typed : pred);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (outcome_q.size() == 0) begin
            if (mismatch_cnt < 10)
               $display("unexpected result: acc=%0b why=%0d lvl=%h cap=%h",
                        rsp_item.accepted, rsp_item.reject_reason,
                        rsp_item.level_read, rsp_item.capacity_read);
            mismatch_cnt++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_item.accepted !== want.accepted ||
                rsp_item.reject_reason !== want.reject_reason ||
                rsp_item.level_read !== want.level_read ||
                rsp_item.capacity_read !== want.capacity_read) begin
               if (mismatch_cnt < 10)
                  $display("result mismatch: expected acc=%0b why=%0d lvl=%h cap=%h, got acc=%0b why=%0d lvl=%h cap=%h",
                           want.accepted, want.reject_reason, want.level_read,
                           want.capacity_read, rsp_item.accepted,
                           rsp_item.reject_reason, rsp_item.level_read,
                           rsp_item.capacity_read);
               mismatch_cnt++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_type      r;
      rsp_type      typed;
      stim_row_type row;
      int unsigned  gap;
      clock        = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_item     = '0;
      mismatch_cnt = 0;
      idle_cycles  = 0;
      foreach (level_tab[k]) begin
         level_tab[k] = '0;
         cap_tab[k]   = '0;
         busy_tab[k]  = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      for (int i = 0; i < ROW_COUNT; i++) begin
         row                    = STIM_ROWS[i];
         r.kind                 = row.kind;
         r.object_index         = row.obj;
         r.partner_index        = row.par;
         r.amount               = row.amt;
         r.level_value          = row.lv;
         r.capacity_value       = row.cv;
         typed.accepted         = row.acc;
         typed.reject_reason    = row.why;
         typed.level_read       = row.lr;
         typed.capacity_read    = row.cr;
         send_item(r, (i % 3 == 0) ? 0 : $urandom_range(2, 0), row.has_exp, typed);
      end
      wait_drained();

      // Random items; each group of 200 starts with a burst sent without gaps, but the second half begins after a drain
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i == RAND_ITEMS / 2) wait_drained();
         gap = (i % 200 < 40) ? 0 : pick_gap();
         if (i == RAND_ITEMS / 2) gap = 1;
         r = random_item();
         send_item(r, gap, 1'b0, '0);
      end

      // Drain and let any stray result show up
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
